/* src/scv_pkg.sv */
// Package for the S-curve step velocity block.
// Holds field widths, register indexes, phase codes and pipeline sideband types.
// No dependencies.
package scv_pkg;

  localparam int STEP_BITS = 24;
  localparam int FRAC_BITS = 16;
  localparam int VEL_BITS  = 24;

  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 24;

  // quotient holds fractions up to and including one
  localparam int Q_BITS     = FRAC_BITS + 1;
  localparam int REM_BITS   = STEP_BITS + 1;
  localparam int DIV_STAGES = Q_BITS;
  localparam int K_BITS     = FRAC_BITS + 3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL_STEPS  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_STEPS   = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_VELOCITY = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_VELOCITY = CFG_IDX_BITS'(3);

  typedef enum logic [1:0] {
    PH_MIN,
    PH_MAX,
    PH_RAMP
  } phase_t;

  typedef struct packed {
    logic   valid;
    phase_t phase;
  } meta_t;

  typedef struct packed {
    logic [STEP_BITS-1:0] total_steps;
    logic [STEP_BITS-1:0] ramp_len;
    logic [VEL_BITS-1:0]  min_velocity;
    logic [VEL_BITS-1:0]  max_velocity;
  } cfg_t;

endpackage

/* src/scv_cfg_regs.sv */
// Configuration registers of the S-curve step velocity block.
// Decodes register writes and derives the effective ramp length.
// Depends on scv_pkg.
module scv_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en_i,
  input  logic [scv_pkg::CFG_IDX_BITS-1:0]  wr_idx_i,
  input  logic [scv_pkg::CFG_DATA_BITS-1:0] wr_data_i,
  output scv_pkg::cfg_t                     cfg_o
);

  logic [scv_pkg::STEP_BITS-1:0] total_steps_r;
  logic [scv_pkg::STEP_BITS-1:0] ramp_steps_r;
  logic [scv_pkg::VEL_BITS-1:0]  min_velocity_r;
  logic [scv_pkg::VEL_BITS-1:0]  max_velocity_r;
  logic [scv_pkg::STEP_BITS-1:0] half_steps;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_steps_r  <= '0;
      ramp_steps_r   <= '0;
      min_velocity_r <= '0;
      max_velocity_r <= '0;
    end else if (wr_en_i) begin
      unique case (wr_idx_i)
        scv_pkg::CFG_TOTAL_STEPS:  total_steps_r  <= wr_data_i[scv_pkg::STEP_BITS-1:0];
        scv_pkg::CFG_RAMP_STEPS:   ramp_steps_r   <= wr_data_i[scv_pkg::STEP_BITS-1:0];
        scv_pkg::CFG_MIN_VELOCITY: min_velocity_r <= wr_data_i[scv_pkg::VEL_BITS-1:0];
        scv_pkg::CFG_MAX_VELOCITY: max_velocity_r <= wr_data_i[scv_pkg::VEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ramp never exceeds half the move
  assign half_steps = total_steps_r >> 1;

  always_comb begin
    cfg_o.total_steps  = total_steps_r;
    cfg_o.ramp_len     = (ramp_steps_r < half_steps) ? ramp_steps_r : half_steps;
    cfg_o.min_velocity = min_velocity_r;
    cfg_o.max_velocity = max_velocity_r;
  end

endmodule

/* src/scv_div.sv */
// Pipelined restoring divider: fraction = num * 2^FRAC_BITS / den, num <= den.
// One quotient bit per stage; sideband travels with each stage.
// Depends on scv_pkg.
module scv_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scv_pkg::meta_t                meta_i,
  input  logic [scv_pkg::STEP_BITS-1:0] num_i,
  input  logic [scv_pkg::STEP_BITS-1:0] den_i,
  output scv_pkg::meta_t                meta_o,
  output logic [scv_pkg::Q_BITS-1:0]    frac_o
);

  localparam int LAST = scv_pkg::DIV_STAGES - 1;

  logic [scv_pkg::REM_BITS-1:0] rem_r  [scv_pkg::DIV_STAGES];
  logic [scv_pkg::Q_BITS-1:0]   q_r    [scv_pkg::DIV_STAGES];
  scv_pkg::meta_t               meta_r [scv_pkg::DIV_STAGES];

  logic [scv_pkg::REM_BITS-1:0] den_ext;
  assign den_ext = {1'b0, den_i};

  for (genvar j = 0; j < scv_pkg::DIV_STAGES; j++) begin : g_stage
    logic [scv_pkg::REM_BITS-1:0] trial;
    logic [scv_pkg::REM_BITS-1:0] rem_nxt;
    logic [scv_pkg::Q_BITS-1:0]   q_nxt;
    logic                         ge;
    scv_pkg::meta_t               meta_nxt;

    if (j == 0) begin : g_first
      // the top quotient bit is set only when num equals den
      assign trial    = {1'b0, num_i};
      assign q_nxt    = {{(scv_pkg::Q_BITS-1){1'b0}}, ge};
      assign meta_nxt = meta_i;
    end else begin : g_next
      // remainder stays below den, so the shift cannot overflow
      assign trial    = {rem_r[j-1][scv_pkg::REM_BITS-2:0], 1'b0};
      assign q_nxt    = {q_r[j-1][scv_pkg::Q_BITS-2:0], ge};
      assign meta_nxt = meta_r[j-1];
    end

    assign ge      = (trial >= den_ext);
    assign rem_nxt = ge ? (trial - den_ext) : trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        meta_r[j] <= '0;
      end else begin
        meta_r[j] <= meta_nxt;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j] <= rem_nxt;
      q_r[j]   <= q_nxt;
    end
  end

  assign meta_o = meta_r[LAST];
  assign frac_o = q_r[LAST];

endmodule

/* src/scv_shape.sv */
// Smoothstep shaping and velocity scaling, four register stages.
// t = f^2, s = t * (3 - 2f), velocity = min + diff * s; drives the result register.
// Depends on scv_pkg.
module scv_shape (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scv_pkg::meta_t                meta_i,
  input  logic [scv_pkg::Q_BITS-1:0]    frac_i,
  input  scv_pkg::cfg_t                 cfg_i,
  output logic                          out_valid_o,
  output logic [scv_pkg::VEL_BITS-1:0]  out_velocity_o
);

  localparam int F  = scv_pkg::FRAC_BITS;
  localparam int QB = scv_pkg::Q_BITS;
  localparam int KB = scv_pkg::K_BITS;
  localparam int VB = scv_pkg::VEL_BITS;

  scv_pkg::meta_t  meta_a_r, meta_b_r, meta_c_r;
  logic [QB-1:0]   t_r;
  logic [KB-1:0]   k_r;
  logic [QB-1:0]   s_r;
  logic [VB-1:0]   p_r;
  logic            out_valid_r;
  logic [VB-1:0]   out_velocity_r;

  logic [2*QB-1:0]   ff_prod;
  logic [KB-1:0]     k_nxt;
  logic [QB+KB-1:0]  tk_prod;
  logic [VB-1:0]     diff;
  logic [VB+QB-1:0]  ds_prod;
  logic [VB-1:0]     out_velocity_nxt;

  assign ff_prod = frac_i * frac_i;
  assign k_nxt   = KB'(3 << F) - {frac_i, 1'b0};
  assign tk_prod = t_r * k_r;
  // only used on ramps, where max is not below min
  assign diff    = cfg_i.max_velocity - cfg_i.min_velocity;
  assign ds_prod = diff * s_r;

  always_comb begin
    unique case (meta_c_r.phase)
      scv_pkg::PH_RAMP: out_velocity_nxt = cfg_i.min_velocity + p_r;
      scv_pkg::PH_MAX:  out_velocity_nxt = cfg_i.max_velocity;
      scv_pkg::PH_MIN:  out_velocity_nxt = cfg_i.min_velocity;
      default:          out_velocity_nxt = cfg_i.min_velocity;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_a_r    <= '0;
      meta_b_r    <= '0;
      meta_c_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      meta_a_r    <= meta_i;
      meta_b_r    <= meta_a_r;
      meta_c_r    <= meta_b_r;
      out_valid_r <= meta_c_r.valid;
    end
  end

  // shaped values never exceed one, so the upper product bits drop out
  always_ff @(posedge clk) begin
    t_r            <= ff_prod[F+QB-1:F];
    k_r            <= k_nxt;
    s_r            <= tk_prod[F+QB-1:F];
    p_r            <= ds_prod[F+VB-1:F];
    out_velocity_r <= out_velocity_nxt;
  end

  assign out_valid_o    = out_valid_r;
  assign out_velocity_o = out_velocity_r;

endmodule

/* src/scurve_step_velocity.sv */
// S-curve step velocity: top level.
// Classifies the step index, then runs divider and smoothstep pipelines.
// Depends on scv_pkg, scv_cfg_regs, scv_div, scv_shape.
//
// Usage:
//   Program total_steps, ramp_steps, min_velocity and max_velocity through
//   the cfg_ channel (index 0..3, other indexes are ignored) while no item
//   is in flight; cfg_ready is always high.
//   Present a step index on in_step_index with start high; busy stays low,
//   so one item is accepted every clock cycle.
//   Each item gives one velocity on out_velocity, marked by out_valid for
//   one cycle. Items leave in order. The path runs through one classify
//   stage, the quotient divider, one bit per stage over 17 stages, and
//   four shaping stages.
//   Throughput is one item per cycle.
//   The receiver cannot stall; out_valid is a strobe.
//   Reset clears the configuration registers to zero and empties the pipeline.
module scurve_step_velocity (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [scv_pkg::STEP_BITS-1:0]     in_step_index,
  output logic                              out_valid,
  output logic [scv_pkg::VEL_BITS-1:0]      out_velocity,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scv_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [scv_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  scv_pkg::cfg_t                 cfg;
  scv_pkg::meta_t                meta_nxt, meta_r;
  logic [scv_pkg::STEP_BITS-1:0] num_nxt, num_r;
  scv_pkg::meta_t                div_meta;
  logic [scv_pkg::Q_BITS-1:0]    div_frac;
  logic [scv_pkg::STEP_BITS-1:0] decel_start;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  scv_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en_i   (cfg_valid && cfg_ready),
    .wr_idx_i  (cfg_index),
    .wr_data_i (cfg_data),
    .cfg_o     (cfg)
  );

  assign decel_start = cfg.total_steps - cfg.ramp_len;

  // sort the index into a phase and pick the divider numerator
  always_comb begin
    meta_nxt.valid = start && !busy;
    meta_nxt.phase = scv_pkg::PH_MIN;
    num_nxt        = in_step_index;
    priority if (cfg.ramp_len == '0 || cfg.max_velocity < cfg.min_velocity) begin
      meta_nxt.phase = scv_pkg::PH_MIN;
    end else if (in_step_index < cfg.ramp_len) begin
      meta_nxt.phase = scv_pkg::PH_RAMP;
    end else if (in_step_index < decel_start) begin
      meta_nxt.phase = scv_pkg::PH_MAX;
    end else if (in_step_index >= cfg.total_steps) begin
      meta_nxt.phase = scv_pkg::PH_MIN;
    end else begin
      meta_nxt.phase = scv_pkg::PH_RAMP;
      num_nxt        = cfg.total_steps - in_step_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r <= '0;
    end else begin
      meta_r <= meta_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
  end

  scv_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .meta_i (meta_r),
    .num_i  (num_r),
    .den_i  (cfg.ramp_len),
    .meta_o (div_meta),
    .frac_o (div_frac)
  );

  scv_shape u_shape (
    .clk            (clk),
    .rst_n          (rst_n),
    .meta_i         (div_meta),
    .frac_i         (div_frac),
    .cfg_i          (cfg),
    .out_valid_o    (out_valid),
    .out_velocity_o (out_velocity)
  );

endmodule

/* bench/scurve_step_velocity_checker.sv */
// Checker for the S-curve step velocity block: predicts and compares velocities.
// Watches the step, velocity and register channels; counts failures for the bench top.
// Depends on scv_pkg.
module scurve_step_velocity_checker
  import scv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [STEP_BITS-1:0]     in_step_index,
  input  logic                     out_valid,
  input  logic [VEL_BITS-1:0]      out_velocity,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STEP_BITS-1:0] step;
    logic [VEL_BITS-1:0]  velocity;
  } velocity_entry_t;

  velocity_entry_t expected_velocity_q[$];

  logic [STEP_BITS-1:0] total_steps_r = '0;
  logic [STEP_BITS-1:0] ramp_steps_r  = '0;
  logic [VEL_BITS-1:0]  min_vel_r     = '0;
  logic [VEL_BITS-1:0]  max_vel_r     = '0;
  int                   mismatches    = 0;

  function automatic logic [VEL_BITS-1:0] velocity_for(logic [STEP_BITS-1:0] idx);
    logic [63:0] total, n, f, t, k, s, vel;
    total = 64'(total_steps_r);
    n     = (64'(ramp_steps_r) < (total >> 1)) ? 64'(ramp_steps_r) : (total >> 1);
    if (n == 0 || max_vel_r < min_vel_r) begin
      return min_vel_r;
    end
    if (64'(idx) < n) begin
      f = (64'(idx) << FRAC_BITS) / n;
    end else if (64'(idx) < total - n) begin
      return max_vel_r;
    end else if (64'(idx) >= total) begin
      f = 0;
    end else begin
      f = ((total - 64'(idx)) << FRAC_BITS) / n;
    end
    // smoothstep 3f^2 - 2f^3 in Q1.FRAC_BITS
    t   = (f * f) >> FRAC_BITS;
    k   = (64'(3) << FRAC_BITS) - 2 * f;
    s   = (t * k) >> FRAC_BITS;
    vel = 64'(min_vel_r) + (((64'(max_vel_r) - 64'(min_vel_r)) * s) >> FRAC_BITS);
    return vel[VEL_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    velocity_entry_t head;
    if (!rst_n) begin
      expected_velocity_q.delete();
      total_steps_r = '0;
      ramp_steps_r  = '0;
      min_vel_r     = '0;
      max_vel_r     = '0;
    end else begin
      if (out_valid) begin
        if (expected_velocity_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("velocity with no item pending: got %0d", out_velocity);
          end
          mismatches++;
        end else begin
          head = expected_velocity_q.pop_front();
          if (out_velocity !== head.velocity) begin
            if (mismatches < 10) begin
              $display("velocity mismatch at step %0d: expected %0d got %0d",
                       head.step, head.velocity, out_velocity);
            end
            mismatches++;
          end
        end
      end
      // predict with the registers as they stand before this edge's write
      if (start && !busy) begin
        expected_velocity_q.push_back('{step: in_step_index,
                                        velocity: velocity_for(in_step_index)});
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TOTAL_STEPS:  total_steps_r = cfg_data[STEP_BITS-1:0];
          CFG_RAMP_STEPS:   ramp_steps_r  = cfg_data[STEP_BITS-1:0];
          CFG_MIN_VELOCITY: min_vel_r     = cfg_data[VEL_BITS-1:0];
          CFG_MAX_VELOCITY: max_vel_r     = cfg_data[VEL_BITS-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= mismatches;
    pending    <= expected_velocity_q.size();
  end

endmodule

/* bench/scurve_step_velocity_tb.sv */
// Bench top for the S-curve step velocity block: clock, reset, stimulus and verdict.
// Drives directed and random moves in bursts; scurve_step_velocity_checker does the checking.
// Depends on scv_pkg, scurve_step_velocity and scurve_step_velocity_checker.
module scurve_step_velocity_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scv_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 32;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 125;
  localparam logic [31:0] VEL_MASK = 32'hFF_FFFF;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [STEP_BITS-1:0]     in_step_index;
  logic                     out_valid;
  logic [VEL_BITS-1:0]      out_velocity;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  int                       fail_count;
  int                       pending;
  int                       cycle_count;
  int                       burst_left;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  scurve_step_velocity i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_step_index (in_step_index),
    .out_valid     (out_valid),
    .out_velocity  (out_velocity),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  scurve_step_velocity_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_step_index (in_step_index),
    .out_valid     (out_valid),
    .out_velocity  (out_velocity),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Send one step index, then close the burst with a random gap now and then.
  task automatic send_step(input logic [STEP_BITS-1:0] idx);
    in_step_index <= idx;
    start         <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end
    end
  endtask

  // Hold off until every velocity has come back, then let the pipeline settle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_move(input logic [31:0] total, input logic [31:0] ramp,
                              input logic [31:0] vmin, input logic [31:0] vmax);
    write_reg(CFG_TOTAL_STEPS, total[CFG_DATA_BITS-1:0]);
    write_reg(CFG_RAMP_STEPS, ramp[CFG_DATA_BITS-1:0]);
    write_reg(CFG_MIN_VELOCITY, vmin[CFG_DATA_BITS-1:0]);
    write_reg(CFG_MAX_VELOCITY, vmax[CFG_DATA_BITS-1:0]);
    // unmapped index: must leave the move untouched
    write_reg(CFG_IDX_BITS'($urandom_range(4, (1 << CFG_IDX_BITS) - 1)),
              CFG_DATA_BITS'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    logic [31:0] total, ramp, vmin, vmax, swap, n, off, idx;
    int          pick;
    case ($urandom_range(0, 3))
      0: begin
        total = $urandom_range(0, 64);
        ramp  = $urandom_range(0, 40);
      end
      1: begin
        total = $urandom_range(0, 5000);
        ramp  = $urandom_range(0, 3000);
      end
      2: begin
        total = $urandom() & VEL_MASK;
        ramp  = $urandom() & VEL_MASK;
      end
      default: begin
        total = $urandom_range(0, 1) ? VEL_MASK : $urandom_range(0, 3);
        ramp  = $urandom_range(0, 1) ? VEL_MASK : $urandom_range(0, 2);
      end
    endcase
    vmin = $urandom() & VEL_MASK;
    vmax = $urandom() & VEL_MASK;
    if (vmax < vmin) begin
      swap = vmin;
      vmin = vmax;
      vmax = swap;
    end
    case ($urandom_range(0, 4))
      0: begin
        vmin = 0;
        vmax = VEL_MASK;
      end
      1: vmax = vmin;
      2: begin
        swap = vmin;
        vmin = vmax;
        vmax = swap;
      end
      default: ;
    endcase
    program_move(total, ramp, vmin, vmax);
    n = (ramp < (total >> 1)) ? ramp : (total >> 1);
    repeat (count) begin
      // aim mostly at the two ramps, where the shaping math runs
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        idx = $urandom_range(0, n + 1);
      end else if (pick < 8) begin
        off = $urandom_range(0, n + 2);
        idx = (total >= off) ? total - off : 0;
      end else if (pick == 8) begin
        idx = $urandom_range(0, total + 4);
      end else begin
        idx = $urandom();
      end
      send_step(idx[STEP_BITS-1:0]);
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_step_index <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    burst_left    = $urandom_range(1, 40);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // registers still at reset: zero ramp
    send_step(24'd0);
    send_step(24'hFF_FFFF);

    drain();
    program_move(100, 20, 1000, 50000);
    send_step(24'd0);
    send_step(24'd1);
    send_step(24'd19);
    send_step(24'd20);
    send_step(24'd50);
    send_step(24'd79);
    send_step(24'd80);
    send_step(24'd99);
    send_step(24'd100);
    send_step(24'hFF_FFFF);

    // max below min
    drain();
    program_move(100, 10, 5000, 100);
    send_step(24'd0);
    send_step(24'd50);
    send_step(24'd95);

    // zero ramp
    drain();
    program_move(100, 0, 7, 900);
    send_step(24'd0);
    send_step(24'd50);

    // ramp longer than half the move
    drain();
    program_move(11, 1000, 10, 20000);
    send_step(24'd0);
    send_step(24'd5);
    send_step(24'd9);

    drain();
    program_move(VEL_MASK, VEL_MASK, 0, VEL_MASK);
    send_step(24'd0);
    send_step(24'h7F_FFFE);
    send_step(24'h7F_FFFF);
    send_step(24'hFF_FFFE);
    send_step(24'hFF_FFFF);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      random_phase(PHASE_ITEMS);
    end

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
